>>> rtl/core/screen_read_reply_deframer_defines.svh
// assertion macros shared by the deframer rtl
`ifndef SCREEN_READ_REPLY_DEFRAMER_DEFINES_SVH
`define SCREEN_READ_REPLY_DEFRAMER_DEFINES_SVH

// clocked check, quiet while reset is asserted
`define SRRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SRRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/srrd_pkg.sv
// types and header constants for the read reply deframer
package srrd_pkg;

  localparam int unsigned WinDepth = 7;

  localparam logic [7:0] SyncFirst   = 8'h5A;
  localparam logic [7:0] SyncSecond  = 8'hA5;
  localparam logic [7:0] ReadCommand = 8'h83;
  localparam logic [7:0] AddrHigh    = 8'h00;

  // header window status seen by the capture control
  typedef struct packed {
    logic       hit;
    logic [7:0] count;
    logic [7:0] addr;
  } win_status_t;

endpackage

>>> rtl/core/screen_read_reply_deframer.sv
// read reply deframer: header hunt, payload capture and result register
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i, in_ready_o, rx_byte_i         | in
//  out     | out_valid_o, out_ready_i, payload_byte_o, | out
//          | payload_index_o, frame_address_o,         |
//          | frame_last_o                              |
//
// one byte beat is taken per cycle while input is not blocked; a payload
// byte shows as the result in the next cycle; header bytes give no beat.
// the capture flag, index and header window update in the accept cycle.
// reset clears the window, capture flag, index and result valid.
// a held result blocks input only when the output stalls; the result
// register frees in the same cycle it is taken.
module screen_read_reply_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] frame_address_o,
  output logic       frame_last_o
);
  import srrd_pkg::*;

  `include "screen_read_reply_deframer_defines.svh"

  localparam logic StHunt = 1'b0;
  localparam logic StCapt = 1'b1;

  logic        state_q, state_d;
  logic [7:0]  pos_q, pos_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, index_q, addr_q;
  logic        last_q;
  logic        in_fire;
  logic        load;
  logic [7:0]  pos_next;
  logic        is_last;
  win_status_t win_st;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  srrd_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (in_fire && (state_q == StHunt)),
    .byte_i   (rx_byte_i),
    .status_o (win_st)
  );

  assign pos_next = pos_q + 8'd1;
  assign is_last  = (pos_next == win_st.count);

  // hunt / capture control
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    load    = 1'b0;
    unique case (state_q)
      StHunt: begin
        if (in_fire && win_st.hit) begin
          state_d = StCapt;
          pos_d   = 8'd0;
        end
      end
      StCapt: begin
        if (in_fire) begin
          load  = 1'b1;
          pos_d = pos_next;
          if (is_last) begin
            state_d = StHunt;
          end
        end
      end
      default: state_d = StHunt;
    endcase
  end

  // result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StHunt;
      pos_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= rx_byte_i;
      index_q <= pos_q;
      addr_q  <= win_st.addr;
      last_q  <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = byte_q;
  assign payload_index_o = index_q;
  assign frame_address_o = addr_q;
  assign frame_last_o    = last_q;

  // checks
  `SRRD_ASSERT(a_hit_starts_capture,
    in_fire && (state_q == StHunt) && win_st.hit |=> (state_q == StCapt) && (pos_q == 8'd0),
    "header match did not start capture at index zero")
  `SRRD_ASSERT(a_last_ends_capture,
    in_fire && (state_q == StCapt) && is_last |=> (state_q == StHunt),
    "last payload byte did not return to hunting")
  `SRRD_ASSERT(a_index_steps,
    in_fire && (state_q == StCapt) && !is_last |=>
      (state_q == StCapt) && (pos_q == 8'($past(pos_q) + 8'd1)),
    "payload index did not advance by one")
  `SRRD_ASSERT(a_hunt_no_beat,
    in_fire && (state_q == StHunt) |=> out_valid_o == $past(out_valid_o && !out_ready_i),
    "header byte produced a result beat")
  `SRRD_ASSERT_ALWAYS(a_reset_idle,
    !rst_ni |-> !out_valid_o && (state_q == StHunt),
    "result valid or capture set during reset")

endmodule

>>> rtl/core/srrd_window.sv
// seven-byte header window with header match and count doubling
module srrd_window (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic [7:0]           byte_i,
  output srrd_pkg::win_status_t status_o
);
  import srrd_pkg::*;

  logic [7:0] win_q [WinDepth];
  logic [7:0] win_d [WinDepth];
  logic [7:0] shifted [WinDepth];
  logic       hit;

  // window as it looks after taking the new byte
  always_comb begin
    for (int k = 0; k < WinDepth - 1; k++) begin
      shifted[k] = win_q[k + 1];
    end
    shifted[WinDepth - 1] = byte_i;
  end

  // header compare on the shifted window
  assign hit = (shifted[0] == SyncFirst) && (shifted[1] == SyncSecond) &&
               (shifted[2] != 8'h00) && (shifted[3] == ReadCommand) &&
               (shifted[4] == AddrHigh) && (shifted[5] != 8'h00) &&
               (shifted[6] != 8'h00);

  // shift while hunting, word count becomes byte count on a match
  always_comb begin
    win_d = win_q;
    if (shift_i) begin
      win_d = shifted;
      if (hit) begin
        win_d[WinDepth - 1] = {shifted[WinDepth - 1][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinDepth; k++) begin
        win_q[k] <= 8'h00;
      end
    end else begin
      win_q <= win_d;
    end
  end

  assign status_o.hit   = hit;
  assign status_o.count = win_q[6];
  assign status_o.addr  = win_q[5];

endmodule

>>> bench/tb.sv
// testbench for the read reply deframer: header hunt, payload capture and checks
module tb;
  import srrd_pkg::*;

  // one expected payload beat
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] addr;
    logic       last;
  } payload_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] payload_byte_o;
  logic [7:0] payload_index_o;
  logic [7:0] frame_address_o;
  logic       frame_last_o;

  // deframer model state
  logic [7:0]    hdr_window [WinDepth];
  logic          in_capture;
  logic [7:0]    pay_pos;
  payload_beat_t expected_payload [$];

  int errors;
  int bytes_sent;
  int burst_left;
  int rx_cycle;

  screen_read_reply_deframer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .frame_address_o (frame_address_o),
    .frame_last_o    (frame_last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  // advance the deframer model by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    payload_beat_t beat;
    logic [7:0]    next_pos;
    if (!in_capture) begin
      for (int k = 0; k < WinDepth - 1; k++) hdr_window[k] = hdr_window[k + 1];
      hdr_window[WinDepth - 1] = b;
      if (hdr_window[0] == SyncFirst && hdr_window[1] == SyncSecond &&
          hdr_window[2] != 8'h00 && hdr_window[3] == ReadCommand &&
          hdr_window[4] == AddrHigh && hdr_window[5] != 8'h00 &&
          hdr_window[6] != 8'h00) begin
        in_capture = 1'b1;
        hdr_window[6] = {hdr_window[6][6:0], 1'b0};
        pay_pos = 8'h00;
      end
    end else begin
      next_pos   = pay_pos + 8'h01;
      beat.data  = b;
      beat.index = pay_pos;
      beat.addr  = hdr_window[5];
      beat.last  = (next_pos == hdr_window[6]);
      pay_pos    = next_pos;
      if (beat.last) in_capture = 1'b0;
      expected_payload.push_back(beat);
    end
  endtask

  // send one byte beat, bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      // every third stretch of 200 bytes runs with no gaps
      gap = ((bytes_sent / 200) % 3 == 2) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] len,
                             input logic [7:0] cmd, input logic [7:0] ahi,
                             input logic [7:0] alo, input logic [7:0] cnt);
    send_byte(s0);
    send_byte(s1);
    send_byte(len);
    send_byte(cmd);
    send_byte(ahi);
    send_byte(alo);
    send_byte(cnt);
  endtask

  // well formed frame with random payload; doubled count of zero means 256 bytes
  task automatic send_frame(input logic [7:0] len, input logic [7:0] alo, input logic [7:0] cnt);
    logic [7:0] dbl;
    int         n;
    dbl = {cnt[6:0], 1'b0};
    n   = (dbl == 8'h00) ? 256 : int'(dbl);
    send_header(SyncFirst, SyncSecond, len, ReadCommand, AddrHigh, alo, cnt);
    repeat (n) send_byte(8'($urandom));
  endtask

  // field extremes, count wrap on a small frame, zero length rejected
  task automatic test_directed();
    send_header(SyncFirst, SyncSecond, 8'h04, ReadCommand, AddrHigh, 8'hFF, 8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(SyncFirst, SyncSecond, 8'hFF, ReadCommand, AddrHigh, 8'h01, 8'h81);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_header(SyncFirst, SyncSecond, 8'h00, ReadCommand, AddrHigh, 8'h01, 8'h01);
  endtask

  // each header field broken once, then a good frame to show recovery
  task automatic test_rejected_headers();
    for (int f = 0; f < WinDepth; f++) begin
      case (f)
        0: send_header(8'h5B, SyncSecond, 8'h02, ReadCommand, AddrHigh, 8'h10, 8'h01);
        1: send_header(SyncFirst, 8'hA4, 8'h02, ReadCommand, AddrHigh, 8'h10, 8'h01);
        2: send_header(SyncFirst, SyncSecond, 8'h00, ReadCommand, AddrHigh, 8'h10, 8'h01);
        3: send_header(SyncFirst, SyncSecond, 8'h02, 8'h82, AddrHigh, 8'h10, 8'h01);
        4: send_header(SyncFirst, SyncSecond, 8'h02, ReadCommand, 8'h01, 8'h10, 8'h01);
        5: send_header(SyncFirst, SyncSecond, 8'h02, ReadCommand, AddrHigh, 8'h00, 8'h01);
        default: send_header(SyncFirst, SyncSecond, 8'h02, ReadCommand, AddrHigh, 8'h10, 8'h00);
      endcase
      send_frame(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 3)));
    end
  endtask

  // doubled count of zero captures 256 bytes, largest plain count 254
  task automatic test_wrapped_count();
    send_frame(8'h10, 8'h7E, 8'h80);
    send_frame(8'h10, 8'h81, 8'hFF);
  endtask

  // mostly good frames with random content, plus noise and broken headers
  task automatic test_random_traffic();
    int         pick;
    logic [7:0] cnt;
    logic [7:0] h [WinDepth];
    while (bytes_sent < 1250) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 9))
          0, 1:    cnt = 8'($urandom_range(8'h81, 8'h88));
          2:       cnt = 8'($urandom_range(9, 24));
          default: cnt = 8'($urandom_range(1, 8));
        endcase
        send_frame(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), cnt);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        h[0] = SyncFirst;
        h[1] = SyncSecond;
        h[2] = 8'($urandom_range(1, 255));
        h[3] = ReadCommand;
        h[4] = AddrHigh;
        h[5] = 8'($urandom_range(1, 255));
        h[6] = 8'($urandom_range(1, 8));
        h[$urandom_range(0, WinDepth - 1)] = 8'($urandom);
        for (int k = 0; k < WinDepth; k++) send_byte(h[k]);
      end
    end
  endtask

  // receiver stall pattern, rotating through always ready, random, rarely ready and mostly ready modes
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_cycle    <= 0;
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 256) % 4)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 7) == 0);
        default: out_ready_i <= (rx_cycle % 5 != 0);
      endcase
    end
  end

  // compare each payload beat with the oldest expectation
  always @(posedge clk_i) begin
    payload_beat_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_payload.size() == 0) begin
        $display("%0t: unexpected beat data %h index %h addr %h last %b", $time,
                 payload_byte_o, payload_index_o, frame_address_o, frame_last_o);
        errors++;
      end else begin
        exp_beat = expected_payload.pop_front();
        if (payload_byte_o !== exp_beat.data) begin
          $display("%0t: payload_byte expected %h got %h", $time, exp_beat.data, payload_byte_o);
          errors++;
        end
        if (payload_index_o !== exp_beat.index) begin
          $display("%0t: payload_index expected %h got %h", $time, exp_beat.index,
                   payload_index_o);
          errors++;
        end
        if (frame_address_o !== exp_beat.addr) begin
          $display("%0t: frame_address expected %h got %h", $time, exp_beat.addr,
                   frame_address_o);
          errors++;
        end
        if (frame_last_o !== exp_beat.last) begin
          $display("%0t: frame_last expected %b got %b", $time, exp_beat.last, frame_last_o);
          errors++;
        end
      end
    end
  end

  // reset, stimulus, drain and verdict
  initial begin
    int waited;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    errors      = 0;
    bytes_sent  = 0;
    burst_left  = 0;
    waited      = 0;
    for (int k = 0; k < WinDepth; k++) hdr_window[k] = 8'h00;
    in_capture = 1'b0;
    pay_pos    = 8'h00;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_rejected_headers();
    test_wrapped_count();
    test_random_traffic();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_payload.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_payload.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_payload.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
